### rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 package
// Shared types and constants for the RC4 stream cipher engine.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int SBOX_DEPTH        = 256;
    localparam int BYTE_W            = 8;
    localparam int SKIP_W            = 16;
    localparam int KEY_BYTES_MAX_DEF = 256;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CRYPT = 2'd1,
        OP_SKIP  = 2'd2
    } t_op;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RD_J     = 9'b000000010,
        ST_WR_I     = 9'b000000100,
        ST_WR_J     = 9'b000001000,
        ST_HOLD     = 9'b000010000,
        ST_KS_RD    = 9'b000100000,
        ST_KS_MIX   = 9'b001000000,
        ST_KS_WR_N  = 9'b010000000,
        ST_KS_WR_A  = 9'b100000000
    } t_state;

    // One access cycle of the permutation memory.
    typedef struct packed {
        logic [BYTE_W-1:0] rd_addr;
        logic              we;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              clear;
    } t_sbox_req;

endpackage

### rtl/rc4_sbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 synchronous memory, one read and one write per cycle, write-first
// on a same-address collision. Per-entry valid bits make an unwritten entry
// read back as its own index, so a clear restores the identity at once.
// ----------------------------------------------------------------------------
module rc4_sbox (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rc4_pkg::t_sbox_req i_req,
    output logic [7:0]         o_rd_data
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0]     r_mem [SBOX_DEPTH];
    logic [SBOX_DEPTH-1:0] r_valid;
    logic [BYTE_W-1:0]     r_rd_data;
    logic [BYTE_W-1:0]     r_rd_addr;
    logic                  r_rd_valid;
    logic                  w_hit;

    assign w_hit = i_req.we && (i_req.rd_addr == i_req.wr_addr);

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data  <= w_hit ? i_req.wr_data : r_mem[i_req.rd_addr];
        r_rd_valid <= w_hit || r_valid[i_req.rd_addr];
        r_rd_addr  <= i_req.rd_addr;
    end

    // Clear wins over a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : r_rd_addr;

endmodule

### rtl/rc4_keybuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 key buffer
// Synchronous key byte memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4_keybuf #(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF,
    parameter int KEY_AW        = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [KEY_AW-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [KEY_AW-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] r_mem [KEY_BYTES_MAX];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/rc4_stream_cipher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Key loading, key schedule and keystream generation around one permutation
// memory and one key buffer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_operation, i_data_byte,
//          |           |                           | i_last_key_byte, i_skip_count
//  out     | output    | o_out_valid / i_out_stall | o_out_byte
//
//  Load: stores a key byte while the buffer has room; a load marked last
//  starts the key schedule: KS_RD once, then KS_MIX, KS_WR_N and KS_WR_A per entry.
//  Crypt: one generator step, through states RD_J, WR_I and WR_J; the next
//  transaction enters in WR_J when the result can leave at the same edge.
//  Skip: one generator step per discarded keystream byte, none for a zero count.
//  Reset (synchronous, active low) restores the identity permutation through
//  valid bits at once, clears i, j and the key length; no clearing pass.
//  A stalled result holds in the output register; the unit then parks until
//  it can hand the result over.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit #(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last_key_byte,
    input  logic [rc4_pkg::SKIP_W-1:0] i_skip_count,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_out_byte
);
    import rc4_pkg::*;

    localparam int KEY_AW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int KEY_LW = $clog2(KEY_BYTES_MAX + 1);

    // Control registers
    t_state            r_state,     n_state;
    logic [BYTE_W-1:0] r_i,         n_i;
    logic [BYTE_W-1:0] r_j,         n_j;
    logic [KEY_LW-1:0] r_len,       n_len;
    logic [SKIP_W-1:0] r_cnt,       n_cnt;
    logic              r_out_valid, n_out_valid;

    // Datapath registers
    logic [BYTE_W-1:0] r_a,   n_a;
    logic [BYTE_W-1:0] r_b,   n_b;
    logic [BYTE_W-1:0] r_acc, n_acc;
    logic [BYTE_W-1:0] r_n,   n_n;
    logic [KEY_AW-1:0] r_k,   n_k;
    logic              r_crypt, n_crypt;
    logic [BYTE_W-1:0] r_data,  n_data;
    logic [BYTE_W-1:0] r_ks,    n_ks;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;

    // Memory interfaces
    t_sbox_req         sbox_req;
    logic [BYTE_W-1:0] sbox_rd;
    logic              key_we;
    logic [KEY_AW-1:0] key_wr_addr;
    logic [KEY_AW-1:0] key_rd_addr;
    logic [BYTE_W-1:0] key_rd;

    logic              out_free;
    logic              in_ready;
    logic              accept;
    logic [BYTE_W-1:0] ks_addr;
    logic [BYTE_W-1:0] ks;
    logic [BYTE_W-1:0] kb;
    logic [KEY_LW-1:0] k_inc;

    rc4_sbox u_sbox (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (sbox_req),
        .o_rd_data (sbox_rd)
    );

    rc4_keybuf #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX),
        .KEY_AW        (KEY_AW)
    ) u_keybuf (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (key_wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_addr (key_rd_addr),
        .o_rd_data (key_rd)
    );

    // Output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    // Take a new transaction when idle, or on the final write of the last
    // generator step, provided a crypt result can leave at the same edge.
    assign in_ready = (r_state == ST_IDLE) ||
                      ((r_state == ST_WR_J) && (r_cnt == SKIP_W'(1)) &&
                       (!r_crypt || out_free));
    assign accept     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // Keystream lookup: S[a+b]. The write of S[j] = a is still pending when
    // the read is issued, so forward a when the address matches j.
    assign ks_addr = r_a + r_b;
    assign ks      = (ks_addr == r_j) ? r_a : sbox_rd;

    // Key byte for the schedule and the cyclic key index.
    assign kb    = (r_len != '0) ? key_rd : '0;
    assign k_inc = KEY_LW'(r_k) + KEY_LW'(1);

    assign key_wr_addr = r_len[KEY_AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_n         = r_n;
        n_k         = r_k;
        n_crypt     = r_crypt;
        n_data      = r_data;
        n_ks        = r_ks;
        n_out_byte  = r_out_byte;

        sbox_req    = '0;
        key_we      = 1'b0;
        key_rd_addr = r_k;

        case (r_state)
            ST_IDLE: begin
            end
            ST_RD_J: begin
                // a = S[i]; advance j and read S[j].
                n_a              = sbox_rd;
                n_j              = r_j + sbox_rd;
                sbox_req.rd_addr = r_j + sbox_rd;
                n_state          = ST_WR_I;
            end
            ST_WR_I: begin
                // b = S[j]; write S[i] = b, read S[a+b].
                n_b              = sbox_rd;
                sbox_req.we      = 1'b1;
                sbox_req.wr_addr = r_i;
                sbox_req.wr_data = sbox_rd;
                sbox_req.rd_addr = r_a + sbox_rd;
                n_state          = ST_WR_J;
            end
            ST_WR_J: begin
                sbox_req.we      = 1'b1;
                sbox_req.wr_addr = r_j;
                sbox_req.wr_data = r_a;
                if (r_cnt != SKIP_W'(1)) begin
                    // Advance again: fold the read of S[i+1] into this cycle.
                    n_cnt            = r_cnt - SKIP_W'(1);
                    n_i              = r_i + BYTE_W'(1);
                    sbox_req.rd_addr = r_i + BYTE_W'(1);
                    n_state          = ST_RD_J;
                end else if (r_crypt) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = r_data ^ ks;
                        n_state     = ST_IDLE;
                    end else begin
                        n_ks    = ks;
                        n_state = ST_HOLD;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ r_ks;
                    n_state     = ST_IDLE;
                end
            end
            ST_KS_RD: begin
                sbox_req.rd_addr = r_n;
                key_rd_addr      = r_k;
                n_state          = ST_KS_MIX;
            end
            ST_KS_MIX: begin
                // held = S[n]; acc += key + held; read S[acc].
                n_a              = sbox_rd;
                n_acc            = r_acc + kb + sbox_rd;
                sbox_req.rd_addr = r_acc + kb + sbox_rd;
                n_state          = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                sbox_req.we      = 1'b1;
                sbox_req.wr_addr = r_n;
                sbox_req.wr_data = sbox_rd;
                n_state          = ST_KS_WR_A;
            end
            ST_KS_WR_A: begin
                sbox_req.we      = 1'b1;
                sbox_req.wr_addr = r_acc;
                sbox_req.wr_data = r_a;
                if (r_n == BYTE_W'(SBOX_DEPTH - 1)) begin
                    n_len   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_n              = r_n + BYTE_W'(1);
                    n_k              = (k_inc >= r_len) ? '0 : k_inc[KEY_AW-1:0];
                    sbox_req.rd_addr = r_n + BYTE_W'(1);
                    key_rd_addr      = (k_inc >= r_len) ? '0 : k_inc[KEY_AW-1:0];
                    n_state          = ST_KS_MIX;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Start a new transaction; overrides the state choice above.
        if (accept) begin
            n_state = ST_IDLE;
            if (i_operation == OP_LOAD) begin
                if (r_len < KEY_LW'(KEY_BYTES_MAX)) begin
                    key_we = 1'b1;
                    n_len  = r_len + KEY_LW'(1);
                end
                if (i_last_key_byte) begin
                    sbox_req.clear = 1'b1;
                    n_i            = '0;
                    n_j            = '0;
                    n_n            = '0;
                    n_k            = '0;
                    n_acc          = '0;
                    n_state        = ST_KS_RD;
                end
            end else if ((i_operation == OP_CRYPT) ||
                         ((i_operation == OP_SKIP) && (i_skip_count != '0))) begin
                n_crypt          = (i_operation == OP_CRYPT);
                n_cnt            = (i_operation == OP_CRYPT) ? SKIP_W'(1) : i_skip_count;
                n_data           = i_data_byte;
                n_i              = r_i + BYTE_W'(1);
                sbox_req.rd_addr = r_i + BYTE_W'(1);
                n_state          = ST_RD_J;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_acc      <= n_acc;
        r_n        <= n_n;
        r_k        <= n_k;
        r_crypt    <= n_crypt;
        r_data     <= n_data;
        r_ks       <= n_ks;
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule

### test/rc4_stream_cipher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher unit testbench
// Drives key loads, crypt bytes, keystream skips and unused operation codes
// through the input channel with random gaps and output stalls. A local
// predictor keeps its own permutation, indices and key buffer. Each output
// byte is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit_test;
    import rc4_pkg::*;

    localparam int          KEY_CAP         = KEY_BYTES_MAX_DEF;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam int unsigned RANDOM_ITEMS    = 510;
    localparam int unsigned LONG_HOLD       = 250;
    // A full 16-bit skip accepts nothing while it runs; the limit outlasts it.
    localparam int unsigned WATCHDOG_LIMIT  = 600000;
    // Tail after the last result; it outlasts one key schedule.
    localparam int unsigned TAIL_CYCLES     = 800;

    typedef struct {
        logic [1:0]        op;
        logic [7:0]        data;
        logic              last;
        logic [SKIP_W-1:0] skip;
        int unsigned       gap;
        bit                drain;
    } t_cipher_txn;

    // DUT ports; the inputs are known from time zero
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation     = '0;
    logic [7:0]        i_data_byte     = '0;
    logic              i_last_key_byte = 1'b0;
    logic [SKIP_W-1:0] i_skip_count    = '0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic [7:0]        o_out_byte;

    // Stimulus and expected output bytes
    t_cipher_txn pending[$];
    logic [7:0]  expected_bytes[$];
    t_cipher_txn cur_txn;
    int unsigned items_queued = 0;

    // Predictor state
    logic [7:0]  sbox_m [256];
    logic [7:0]  key_buf_m [KEY_CAP];
    logic [7:0]  idx_i_m;
    logic [7:0]  idx_j_m;
    int unsigned key_len_m;

    // Bookkeeping
    int unsigned gap_left       = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned error_count    = 0;
    int unsigned n_accepted     = 0;
    int unsigned n_checked      = 0;
    int unsigned n_schedules    = 0;
    int unsigned n_skipped      = 0;
    logic [7:0]  exp_byte;

    rc4_stream_cipher_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_last_key_byte (i_last_key_byte),
        .i_skip_count    (i_skip_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Advance the generator by one step and return the keystream byte.
    function automatic logic [7:0] next_keystream();
        logic [7:0] a;
        logic [7:0] b;
        idx_i_m = idx_i_m + 8'd1;
        a = sbox_m[idx_i_m];
        idx_j_m = idx_j_m + a;
        b = sbox_m[idx_j_m];
        sbox_m[idx_i_m] = b;
        sbox_m[idx_j_m] = a;
        return sbox_m[8'(a + b)];
    endfunction

    // Identity permutation, clear indices, mix in the stored key cyclically, then empty the key.
    function automatic void mix_key();
        int unsigned k;
        logic [7:0]  acc;
        logic [7:0]  held;
        logic [7:0]  kb;
        k   = 0;
        acc = '0;
        for (int n = 0; n < 256; n++) sbox_m[n] = 8'(n);
        idx_i_m = '0;
        idx_j_m = '0;
        for (int n = 0; n < 256; n++) begin
            held = sbox_m[n];
            // An empty key cannot reach here; mix a zero byte if it ever did
            kb   = (key_len_m != 0) ? key_buf_m[k] : 8'd0;
            acc  = acc + kb + held;
            sbox_m[n]   = sbox_m[acc];
            sbox_m[acc] = held;
            k++;
            if (k >= key_len_m) k = 0;
        end
        key_len_m = 0;
    endfunction

    // Apply one accepted transaction to the predictor; queue the byte a crypt returns.
    function automatic void predict_transaction(input t_cipher_txn t);
        case (t.op)
            OP_LOAD: begin
                // Bytes past a full key buffer are dropped, but the mark still counts
                if (key_len_m < KEY_CAP) begin
                    key_buf_m[key_len_m] = t.data;
                    key_len_m++;
                end
                if (t.last) begin
                    mix_key();
                    n_schedules++;
                end
            end
            OP_CRYPT: begin
                expected_bytes.push_back(t.data ^ next_keystream());
            end
            OP_SKIP: begin
                for (int unsigned n = 0; n < t.skip; n++) void'(next_keystream());
                n_skipped += t.skip;
            end
            default: begin
                // unused operation code: no state change, no output
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle cycles before a transaction: runs of back-to-back traffic, otherwise
    // occasional gaps of random length.
    function automatic int unsigned draw_wait(input int unsigned seq);
        if ((seq / 40) % 3 == 1) return 0;
        if ($urandom_range(0, 3) != 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Mostly short skips, now and then 64 to 1500 bytes.
    function automatic logic [SKIP_W-1:0] draw_skip();
        if ($urandom_range(0, 15) == 0) return SKIP_W'($urandom_range(64, 1500));
        return SKIP_W'($urandom_range(0, 40));
    endfunction

    task automatic push_txn(input logic [1:0] op, input logic [7:0] data,
                            input logic last, input logic [SKIP_W-1:0] skip);
        t_cipher_txn t;
        t.op    = op;
        t.data  = data;
        t.last  = last;
        t.skip  = skip;
        t.gap   = draw_wait(items_queued);
        t.drain = 1'b0;
        pending.push_back(t);
        if (op != OP_UNUSED) items_queued++;
    endtask

    // Hold the sender until every predicted byte has come back.
    task automatic push_drain();
        t_cipher_txn t;
        t       = '{default: '0};
        t.drain = 1'b1;
        pending.push_back(t);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned directed_count;
        int unsigned key_len;
        int unsigned run_len;
        int unsigned pick;
        logic [1:0]  op;
        bit          long_key_done;
        bit          mid_drain_done;

        long_key_done  = 1'b0;
        mid_drain_done = 1'b0;

        // Predictor reset state
        for (int n = 0; n < 256; n++) sbox_m[n] = 8'(n);
        for (int n = 0; n < KEY_CAP; n++) key_buf_m[n] = '0;
        idx_i_m   = '0;
        idx_j_m   = '0;
        key_len_m = 0;

        // Directed: generator on the reset permutation before any key
        push_txn(OP_CRYPT, 8'h00, 1'b0, 16'h0000);
        push_txn(OP_CRYPT, 8'hFF, 1'b0, 16'hFFFF);
        // zero-length skip, mark ignored off a load
        push_txn(OP_SKIP,  8'hFF, 1'b1, 16'h0000);
        // unused operation code with every other field set
        push_txn(OP_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
        // three-byte key
        push_txn(OP_LOAD,  8'h00, 1'b0, 16'h0000);
        push_txn(OP_LOAD,  8'hFF, 1'b0, 16'hFFFF);
        push_txn(OP_LOAD,  8'h5A, 1'b1, 16'h0000);
        push_txn(OP_CRYPT, 8'h00, 1'b1, 16'h0000);
        push_txn(OP_CRYPT, 8'hFF, 1'b0, 16'h0000);
        // longest skip the field allows
        push_txn(OP_SKIP,  8'h00, 1'b0, 16'hFFFF);
        push_txn(OP_CRYPT, 8'hA5, 1'b0, 16'h0000);
        // one-byte key
        push_txn(OP_LOAD,  8'hFF, 1'b1, 16'h0000);
        push_txn(OP_CRYPT, 8'h00, 1'b0, 16'h0000);
        push_txn(OP_SKIP,  8'h00, 1'b0, 16'h0001);
        push_txn(OP_CRYPT, 8'h3C, 1'b0, 16'h0000);
        push_drain();
        push_txn(OP_CRYPT, 8'hC3, 1'b0, 16'h0000);
        directed_count = items_queued;

        // Random: mostly key-then-traffic sequences, some noise
        while (items_queued < directed_count + RANDOM_ITEMS) begin
            if (!long_key_done && items_queued > directed_count + 120) begin
                // Oversized key: the tail bytes drop, the last one still schedules
                for (int k = 0; k < KEY_CAP + 2; k++)
                    push_txn(OP_LOAD, 8'($urandom), k == KEY_CAP + 1, SKIP_W'($urandom));
                long_key_done = 1'b1;
            end
            if (!mid_drain_done && items_queued > directed_count + 420) begin
                push_drain();
                mid_drain_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                      : $urandom_range(1, 16);
                for (int unsigned k = 0; k < key_len; k++)
                    push_txn(OP_LOAD, 8'($urandom), k == key_len - 1, SKIP_W'($urandom));
                run_len = $urandom_range(4, 30);
                for (int unsigned r = 0; r < run_len; r++) begin
                    if ($urandom_range(0, 7) == 0)
                        push_txn(OP_SKIP, 8'($urandom), 1'($urandom), draw_skip());
                    else
                        push_txn(OP_CRYPT, 8'($urandom), 1'($urandom), SKIP_W'($urandom));
                end
            end else begin
                run_len = $urandom_range(1, 6);
                for (int unsigned r = 0; r < run_len; r++) begin
                    op = 2'($urandom_range(0, 3));
                    if (op == OP_LOAD)
                        push_txn(op, 8'($urandom), $urandom_range(0, 3) == 0,
                                 SKIP_W'($urandom));
                    else if (op == OP_SKIP)
                        push_txn(op, 8'($urandom), 1'($urandom), draw_skip());
                    else
                        push_txn(op, 8'($urandom), 1'($urandom), SKIP_W'($urandom));
                end
            end
        end
        // End on results so nothing silent is left running
        for (int r = 0; r < 3; r++) push_txn(OP_CRYPT, 8'($urandom), 1'b0, 16'h0000);

        // Hold reset, then release it for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input transactions, %0d key schedules, %0d skipped bytes;",
                 n_accepted, n_schedules, n_skipped);
        $display("%0d output bytes compared, %0d mismatches.", n_checked, error_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: feed queued transactions to the input channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Predict at the edge that takes the transaction
            if (i_in_valid && !o_in_stall) begin
                predict_transaction(cur_txn);
                n_accepted++;
            end
            // Advance only when the channel is free; a stalled payload holds
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending.size() != 0 && pending[0].drain) begin
                    // Pause the sender until all predicted bytes are back
                    i_in_valid <= 1'b0;
                    if (expected_bytes.size() == 0) void'(pending.pop_front());
                end else if (pending.size() != 0) begin
                    cur_txn = pending.pop_front();
                    i_operation     <= cur_txn.op;
                    i_data_byte     <= cur_txn.data;
                    i_last_key_byte <= cur_txn.last;
                    i_skip_count    <= cur_txn.skip;
                    i_in_valid      <= 1'b1;
                    // Gap before the next transaction starts counting after this one goes
                    gap_left = (pending.size() != 0) ? pending[0].gap : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take output bytes and compare with the predictor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    error_count++;
                    $display("%0t: out_byte expected none, actual %02h", $time, o_out_byte);
                end else begin
                    exp_byte = expected_bytes.pop_front();
                    if (o_out_byte !== exp_byte) begin
                        error_count++;
                        $display("%0t: out_byte expected %02h, actual %02h",
                                 $time, exp_byte, o_out_byte);
                    end
                end
                n_checked++;
                // Twice in the run, hold off long enough that the unit backs up
                // and stalls its input while the sender keeps offering
                if (n_checked == 30 || n_checked == 120)
                    hold_left = LONG_HOLD;
                else
                    hold_left = draw_wait(n_checked);
            end else if (hold_left != 0) begin
                hold_left--;
            end
            i_out_stall <= (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, giving up", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
